/* rtl/qtpp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared types and codes for the transport-parameter parser.
// No dependencies; every other file of the block but qtpp_fifo imports this package.
package qtpp_pkg;

    // Result kinds
    localparam logic [1:0] KIND_NUM   = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    // Block-end status codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_TRUNC     = 3'd1;
    localparam logic [2:0] STAT_OVERRUN   = 3'd2;
    localparam logic [2:0] STAT_NUM_LEN   = 3'd3;
    localparam logic [2:0] STAT_TOKEN_LEN = 3'd4;
    localparam logic [2:0] STAT_FLAG      = 3'd5;

    localparam logic [61:0] TOKEN_LEN = 62'd16;

    // Byte as classified by the front end
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [2:0] extra;  // bytes that follow a varint starting with this byte
        logic [3:0] vlen;   // total varint size starting with this byte
    } t_mid_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [61:0] param_id;
        logic [61:0] param_value;
        logic [7:0]  value_byte;
        logic        value_last;
        logic        block_end;
        logic [2:0]  status;
    } t_result;

endpackage
`default_nettype wire

/* rtl/quic_transport_param_parser_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Transport-parameter block parser: top level.
// Depends on qtpp_pkg, qtpp_front, qtpp_back and qtpp_fifo.
//
// Usage:
//   Input channel (push/full) carries the encoded block one byte per transfer,
//   with i_wire_last set on the final byte. Output channel (empty/pop) carries
//   results: numeric values, opaque value bytes, empty-value entries, and one
//   result with o_block_end set per block, carrying the status.
//   A byte causes zero or one result; the last byte always causes one.
// Path: a transferred byte is stored in the front queue; the parser reads the
//   front queue head and writes the result into the result queue, whose head
//   drives the output ports.
// Throughput: one byte per cycle, sustained, as long as the receiver pops;
//   set by the parser, which retires one byte each cycle.
// Stall: when the result queue fills, the parser holds; the front queue then
//   fills and full rises. Nothing is lost or repeated.
// Reset: synchronous, active low. Both queues empty and the parser returns to
//   the start of an entry id with no error pending.
module quic_transport_param_parser_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte input
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_wire_byte,
    input  wire logic        i_wire_last,
    // result output
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_kind,
    output logic [61:0]      o_param_id,
    output logic [61:0]      o_param_value,
    output logic [7:0]       o_value_byte,
    output logic             o_value_last,
    output logic             o_block_end,
    output logic [2:0]       o_status
);
    import qtpp_pkg::*;

    t_mid_item                  mid_item;
    logic                       mid_valid;
    logic                       mid_pop;
    t_result                    back_res;
    logic                       res_push;
    logic                       res_full;
    logic [$bits(t_result)-1:0] out_data;
    t_result                    out_res;

    // Classify and queue incoming bytes
    qtpp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_wire_byte (i_wire_byte),
        .i_wire_last (i_wire_last),
        .o_full      (full),
        .i_pop       (mid_pop),
        .o_item      (mid_item),
        .o_valid     (mid_valid)
    );

    // Advance the entry parser one byte per cycle while the result queue has room
    qtpp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (mid_item),
        .i_valid    (mid_valid),
        .o_pop      (mid_pop),
        .o_res      (back_res),
        .o_res_push (res_push),
        .i_res_full (res_full)
    );

    // Hold results until the receiver takes them
    qtpp_fifo #(
        .W($bits(t_result))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty)
    );

    assign out_res       = t_result'(out_data);
    assign o_kind        = out_res.kind;
    assign o_param_id    = out_res.param_id;
    assign o_param_value = out_res.param_value;
    assign o_value_byte  = out_res.value_byte;
    assign o_value_last  = out_res.value_last;
    assign o_block_end   = out_res.block_end;
    assign o_status      = out_res.status;

endmodule
`default_nettype wire

/* rtl/qtpp_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// Two-entry queue with push/full and pop/empty handshakes.
// Generic in data width; no package dependency.
module qtpp_fifo #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);
    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          push_ok, pop_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr  = push_ok ? AW'((int'(r_wr) + 1) % DEPTH) : r_wr;
        n_rd  = pop_ok ? AW'((int'(r_rd) + 1) % DEPTH) : r_rd;
        n_cnt = r_cnt + CW'(push_ok) - CW'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

/* rtl/qtpp_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// Front end: accept wire bytes, decode the varint size prefix, queue them.
// Depends on qtpp_pkg and qtpp_fifo.
module qtpp_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [7:0]       i_wire_byte,
    input  wire logic             i_wire_last,
    output logic                  o_full,
    input  wire logic             i_pop,
    output qtpp_pkg::t_mid_item   o_item,
    output logic                  o_valid
);
    import qtpp_pkg::*;

    t_mid_item                  cls_item;
    logic [$bits(t_mid_item)-1:0] q_data;
    logic                       q_empty;

    // Size prefix: top two bits select 1, 2, 4 or 8 bytes
    always_comb begin
        cls_item.data = i_wire_byte;
        cls_item.last = i_wire_last;
        unique case (i_wire_byte[7:6])
            2'b00: begin cls_item.extra = 3'd0; cls_item.vlen = 4'd1; end
            2'b01: begin cls_item.extra = 3'd1; cls_item.vlen = 4'd2; end
            2'b10: begin cls_item.extra = 3'd3; cls_item.vlen = 4'd4; end
            2'b11: begin cls_item.extra = 3'd7; cls_item.vlen = 4'd8; end
            default: begin cls_item.extra = 3'd0; cls_item.vlen = 4'd1; end
        endcase
    end

    qtpp_fifo #(
        .W($bits(t_mid_item))
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cls_item),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    assign o_item  = t_mid_item'(q_data);
    assign o_valid = !q_empty;

endmodule
`default_nettype wire

/* rtl/qtpp_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// Back end: entry parser state machine, one classified byte per cycle while the result queue has room.
// Depends on qtpp_pkg.
module qtpp_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire qtpp_pkg::t_mid_item  i_item,
    input  wire logic                 i_valid,
    output logic                      o_pop,
    output qtpp_pkg::t_result         o_res,
    output logic                      o_res_push,
    input  wire logic                 i_res_full
);
    import qtpp_pkg::*;

    localparam logic [1:0] PH_ID   = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_VAL  = 2'd2;
    localparam logic [1:0] PH_HALT = 2'd3;

    localparam logic [1:0] CLS_NUM    = 2'd0;
    localparam logic [1:0] CLS_OPAQUE = 2'd1;
    localparam logic [1:0] CLS_TOKEN  = 2'd2;
    localparam logic [1:0] CLS_FLAG   = 2'd3;

    function automatic logic [1:0] id_class(input logic [61:0] id);
        logic [1:0] c;
        if (id == 62'h1 || (id >= 62'h3 && id <= 62'hb) || id == 62'he) begin
            c = CLS_NUM;
        end else if (id == 62'h2) begin
            c = CLS_TOKEN;
        end else if (id == 62'hc) begin
            c = CLS_FLAG;
        end else begin
            c = CLS_OPAQUE;
        end
        return c;
    endfunction

    logic [1:0]  r_phase, n_phase;
    logic [2:0]  r_vbl, n_vbl;
    logic [61:0] r_vacc, n_vacc;
    logic [61:0] r_cur_id, n_cur_id;
    logic [1:0]  r_cls, n_cls;
    logic [61:0] r_vleft, n_vleft;
    logic        r_ipos, n_ipos;
    logic [61:0] r_valacc, n_valacc;
    logic [2:0]  r_err, n_err;

    logic        fire;
    logic        have;
    logic [61:0] vleft_dec;
    t_result     res;

    assign fire       = i_valid && !i_res_full;
    assign o_pop      = fire;
    assign o_res_push = fire && (have || i_item.last);
    assign o_res      = res;
    assign vleft_dec  = r_vleft - 62'd1;

    always_comb begin
        n_phase  = r_phase;
        n_vbl    = r_vbl;
        n_vacc   = r_vacc;
        n_cur_id = r_cur_id;
        n_cls    = r_cls;
        n_vleft  = r_vleft;
        n_ipos   = r_ipos;
        n_valacc = r_valacc;
        n_err    = r_err;
        have     = 1'b0;
        res      = '0;
        res.kind = KIND_END;

        unique case (r_phase)
            PH_ID, PH_LEN: begin
                if (r_vbl == 3'd0) begin
                    n_vacc = {56'd0, i_item.data[5:0]};
                    n_vbl  = i_item.extra;
                end else begin
                    n_vacc = {r_vacc[53:0], i_item.data};
                    n_vbl  = r_vbl - 3'd1;
                end
                if (n_vbl == 3'd0) begin
                    if (r_phase == PH_ID) begin
                        n_cur_id = n_vacc;
                        n_cls    = id_class(n_vacc);
                        n_phase  = PH_LEN;
                    end else begin
                        n_vleft  = n_vacc;
                        n_valacc = '0;
                        n_ipos   = 1'b0;
                        if (n_vacc == '0) begin
                            priority if (r_cls == CLS_NUM) begin
                                n_err   = STAT_NUM_LEN;
                                n_phase = PH_HALT;
                            end else if (r_cls == CLS_TOKEN) begin
                                n_err   = STAT_TOKEN_LEN;
                                n_phase = PH_HALT;
                            end else begin
                                have         = 1'b1;
                                res.kind     = KIND_EMPTY;
                                res.param_id = r_cur_id;
                                n_phase      = PH_ID;
                            end
                        end else begin
                            // Note the error now, skip the value first
                            if (r_cls == CLS_FLAG) begin
                                n_err = STAT_FLAG;
                            end else if (r_cls == CLS_TOKEN && n_vacc != TOKEN_LEN) begin
                                n_err = STAT_TOKEN_LEN;
                            end
                            n_phase = PH_VAL;
                        end
                    end
                    n_vacc = '0;
                end
            end
            PH_VAL: begin
                n_vleft = vleft_dec;
                if (r_err == STAT_OK) begin
                    if (r_cls == CLS_NUM) begin
                        if (!r_ipos) begin
                            n_ipos   = 1'b1;
                            n_valacc = {56'd0, i_item.data[5:0]};
                            if (r_vleft != {58'd0, i_item.vlen}) begin
                                n_err = STAT_NUM_LEN;
                            end
                        end else begin
                            n_valacc = {r_valacc[53:0], i_item.data};
                        end
                    end else begin
                        have           = 1'b1;
                        res.kind       = KIND_BYTE;
                        res.param_id   = r_cur_id;
                        res.value_byte = i_item.data;
                        res.value_last = (vleft_dec == '0);
                    end
                end
                if (vleft_dec == '0) begin
                    if (n_err != STAT_OK) begin
                        n_phase = PH_HALT;
                    end else begin
                        if (r_cls == CLS_NUM) begin
                            have            = 1'b1;
                            res.kind        = KIND_NUM;
                            res.param_id    = r_cur_id;
                            res.param_value = n_valacc;
                        end
                        n_phase = PH_ID;
                    end
                    n_valacc = '0;
                    n_ipos   = 1'b0;
                end
            end
            PH_HALT: begin
                // drop bytes until the block ends
            end
            default: begin
            end
        endcase

        if (i_item.last) begin
            res.block_end = 1'b1;
            unique case (n_phase)
                PH_HALT: res.status = n_err;
                PH_VAL:  res.status = STAT_OVERRUN;
                PH_LEN:  res.status = STAT_TRUNC;
                PH_ID:   res.status = (n_vbl != 3'd0) ? STAT_TRUNC : STAT_OK;
                default: res.status = STAT_OK;
            endcase
            n_phase  = PH_ID;
            n_vbl    = '0;
            n_vacc   = '0;
            n_cur_id = '0;
            n_cls    = id_class('0);
            n_vleft  = '0;
            n_ipos   = 1'b0;
            n_valacc = '0;
            n_err    = STAT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_ID;
            r_vbl    <= '0;
            r_vacc   <= '0;
            r_cur_id <= '0;
            r_cls    <= CLS_OPAQUE;
            r_vleft  <= '0;
            r_ipos   <= 1'b0;
            r_valacc <= '0;
            r_err    <= STAT_OK;
        end else if (fire) begin
            r_phase  <= n_phase;
            r_vbl    <= n_vbl;
            r_vacc   <= n_vacc;
            r_cur_id <= n_cur_id;
            r_cls    <= n_cls;
            r_vleft  <= n_vleft;
            r_ipos   <= n_ipos;
            r_valacc <= n_valacc;
            r_err    <= n_err;
        end
    end

endmodule
`default_nettype wire

/* rtl/qtpp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks for the transport-parameter parser, bound to the top level.
// Depends on qtpp_pkg.
module qtpp_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        full,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic [1:0]  o_kind,
    input  wire logic [61:0] o_param_id,
    input  wire logic [61:0] o_param_value,
    input  wire logic [7:0]  o_value_byte,
    input  wire logic        o_value_last,
    input  wire logic        o_block_end,
    input  wire logic [2:0]  o_status
);
    import qtpp_pkg::*;

    // Reset leaves the result queue empty and the input queue not full
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // A waiting result holds until popped
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_kind) && $stable(o_param_id)
            && $stable(o_param_value) && $stable(o_value_byte)
            && $stable(o_value_last) && $stable(o_block_end) && $stable(o_status))
        else $error("stalled result changed");

    // Status only on block end
    a_status_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_block_end |-> o_status == STAT_OK)
        else $error("status set without block end");

    // End-only kind always closes the block and carries a zero id
    a_kind_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_kind == KIND_END |-> o_block_end && o_param_id == '0)
        else $error("end-only result without block end");

    // Opaque-last flag only on opaque bytes
    a_vlast_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_value_last |-> o_kind == KIND_BYTE)
        else $error("value_last on non-byte result");

endmodule

bind quic_transport_param_parser_unit qtpp_checker u_qtpp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_kind        (o_kind),
    .o_param_id    (o_param_id),
    .o_param_value (o_param_value),
    .o_value_byte  (o_value_byte),
    .o_value_last  (o_value_last),
    .o_block_end   (o_block_end),
    .o_status      (o_status)
);
`default_nettype wire

/* tb/sv/tb_quic_transport_param_parser_unit.sv */
`timescale 1ns / 1ps
// Self-checking bench for the QUIC transport-parameter parser: directed table, then random blocks.
// Depends on qtpp_pkg and quic_transport_param_parser_unit; each result is checked against a
// byte-level decoder written here, or against the result typed in for a directed closing row.
module tb_quic_transport_param_parser_unit;
    import qtpp_pkg::*;

    localparam int RANDOM_BYTES   = 1100;
    localparam int CALM_TAIL      = 150;   // last bytes sent with no idling on either side
    localparam int HOLD_AT        = 300;   // bytes sent before the long receiver hold-off
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 200;

    // Decoder position inside an entry
    typedef enum logic [1:0] {PH_ID, PH_LEN, PH_VAL, PH_HALT} t_phase;
    // How an id's value is handled
    typedef enum logic [1:0] {PC_NUM, PC_OPAQUE, PC_TOKEN, PC_FLAG} t_pclass;

    // One byte to send; when fixed is set, res is the result typed in for it
    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       fixed;
        t_result    res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic        pop         = 1'b0;
    logic [7:0]  i_wire_byte = 8'h00;
    logic        i_wire_last = 1'b0;
    logic        full;
    logic        empty;
    logic [1:0]  o_kind;
    logic [61:0] o_param_id;
    logic [61:0] o_param_value;
    logic [7:0]  o_value_byte;
    logic        o_value_last;
    logic        o_block_end;
    logic [2:0]  o_status;

    quic_transport_param_parser_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_wire_byte   (i_wire_byte),
        .i_wire_last   (i_wire_last),
        .empty         (empty),
        .pop           (pop),
        .o_kind        (o_kind),
        .o_param_id    (o_param_id),
        .o_param_value (o_param_value),
        .o_value_byte  (o_value_byte),
        .o_value_last  (o_value_last),
        .o_block_end   (o_block_end),
        .o_status      (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Decoder state, kept in step with the block at each byte transfer
    // ------------------------------------------------------------------
    t_phase      dec_phase;
    logic [2:0]  dec_vint_left;   // bytes still due in the id or length varint
    logic [61:0] dec_vint_acc;
    logic [61:0] dec_id;
    logic [61:0] dec_val_left;    // value bytes still due
    logic [3:0]  dec_num_len;
    logic        dec_num_seen;
    logic [61:0] dec_num_acc;
    logic [2:0]  dec_err;

    t_row    byte_q[$];          // bytes waiting to be offered
    t_row    blk_q[$];           // block under construction
    t_result pending_results[$]; // results owed by the block, oldest first

    t_row cur;                   // byte now on the input ports
    bit   run_io       = 1'b0;
    int   sent_cnt     = 0;
    int   total_bytes  = 0;
    int   err_cnt      = 0;
    int   kind_cnt [4] = '{0, 0, 0, 0};
    int   block_cnt    = 0;
    int   full_stalls  = 0;
    int   tx_gap       = 0;
    int   rx_gap       = 0;
    int   tx_pct       = 20;
    int   rx_pct       = 20;
    int   rx_hold_cnt  = 0;
    bit   hold_done    = 1'b0;
    bit   calm         = 1'b0;
    int   stall_cycles = 0;

    function automatic t_pclass param_class(input logic [61:0] id);
        if (id == 62'h01 || (id >= 62'h03 && id <= 62'h0b) || id == 62'h0e)
            return PC_NUM;
        if (id == 62'h02)
            return PC_TOKEN;
        if (id == 62'h0c)
            return PC_FLAG;
        return PC_OPAQUE;
    endfunction

    task automatic clear_decoder();
        dec_phase     = PH_ID;
        dec_vint_left = '0;
        dec_vint_acc  = '0;
        dec_id        = '0;
        dec_val_left  = '0;
        dec_num_len   = '0;
        dec_num_seen  = 1'b0;
        dec_num_acc   = '0;
        dec_err       = STAT_OK;
    endtask

    // Advance the decoder by one byte; produced tells whether a result is owed.
    task automatic decode_byte(input logic [7:0] b, input logic last,
                               output bit produced, output t_result r);
        logic [61:0] v;
        logic [61:0] prev_left;
        t_pclass     cls;
        produced = 1'b0;
        r        = '0;
        r.kind   = KIND_END;
        cls      = param_class(dec_id);
        case (dec_phase)
            PH_ID, PH_LEN: begin
                if (dec_vint_left == 0) begin
                    dec_vint_acc  = {56'd0, b[5:0]};
                    dec_vint_left = 3'((4'd1 << b[7:6]) - 4'd1);
                end else begin
                    dec_vint_acc  = {dec_vint_acc[53:0], b};
                    dec_vint_left = dec_vint_left - 3'd1;
                end
                if (dec_vint_left == 0) begin
                    v            = dec_vint_acc;
                    dec_vint_acc = '0;
                    if (dec_phase == PH_ID) begin
                        dec_id    = v;
                        dec_phase = PH_LEN;
                    end else begin
                        dec_val_left = v;
                        dec_num_acc  = '0;
                        dec_num_len  = '0;
                        dec_num_seen = 1'b0;
                        if (v == 0) begin
                            // empty value: fatal for numeric and token, reported otherwise
                            if (cls == PC_NUM) begin
                                dec_err   = STAT_NUM_LEN;
                                dec_phase = PH_HALT;
                            end else if (cls == PC_TOKEN) begin
                                dec_err   = STAT_TOKEN_LEN;
                                dec_phase = PH_HALT;
                            end else begin
                                produced   = 1'b1;
                                r.kind     = KIND_EMPTY;
                                r.param_id = dec_id;
                                dec_phase  = PH_ID;
                            end
                        end else begin
                            // note the error now, skip the value anyway
                            if (cls == PC_FLAG)
                                dec_err = STAT_FLAG;
                            else if (cls == PC_TOKEN && v != TOKEN_LEN)
                                dec_err = STAT_TOKEN_LEN;
                            dec_phase = PH_VAL;
                        end
                    end
                end
            end
            PH_VAL: begin
                prev_left    = dec_val_left;
                dec_val_left = dec_val_left - 62'd1;
                if (dec_err == STAT_OK) begin
                    if (cls == PC_NUM) begin
                        if (!dec_num_seen) begin
                            dec_num_len  = 4'd1 << b[7:6];
                            dec_num_seen = 1'b1;
                            if (prev_left != {58'd0, dec_num_len})
                                dec_err = STAT_NUM_LEN;
                            dec_num_acc = {56'd0, b[5:0]};
                        end else begin
                            dec_num_acc = {dec_num_acc[53:0], b};
                        end
                    end else begin
                        produced     = 1'b1;
                        r.kind       = KIND_BYTE;
                        r.param_id   = dec_id;
                        r.value_byte = b;
                        r.value_last = (dec_val_left == 0);
                    end
                end
                if (dec_val_left == 0) begin
                    if (dec_err != STAT_OK) begin
                        dec_phase = PH_HALT;
                    end else begin
                        if (cls == PC_NUM) begin
                            produced      = 1'b1;
                            r.kind        = KIND_NUM;
                            r.param_id    = dec_id;
                            r.param_value = dec_num_acc;
                        end
                        dec_phase = PH_ID;
                    end
                    dec_num_acc  = '0;
                    dec_num_len  = '0;
                    dec_num_seen = 1'b0;
                end
            end
            default: ;  // halted: drop bytes until the end of the block
        endcase
        if (last) begin
            produced    = 1'b1;
            r.block_end = 1'b1;
            case (dec_phase)
                PH_HALT: r.status = dec_err;
                PH_VAL:  r.status = STAT_OVERRUN;
                PH_LEN:  r.status = STAT_TRUNC;
                default: r.status = (dec_vint_left != 0) ? STAT_TRUNC : STAT_OK;
            endcase
            clear_decoder();
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_row plain(input logic [7:0] b, input logic last);
        t_row t;
        t       = '0;
        t.b     = b;
        t.last  = last;
        return t;
    endfunction

    // Last byte of a block whose closing result is known at a glance
    function automatic t_row closing(input logic [7:0] b, input logic [1:0] k,
                                     input logic [61:0] id, input logic [61:0] val,
                                     input logic [2:0] st);
        t_row t;
        t                   = plain(b, 1'b1);
        t.fixed             = 1'b1;
        t.res.kind          = k;
        t.res.param_id      = id;
        t.res.param_value   = val;
        t.res.block_end     = 1'b1;
        t.res.status        = st;
        return t;
    endfunction

    function automatic logic [61:0] rand62();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[61:0];
    endfunction

    // Varint size in bytes: the smallest that fits, sometimes a wider one
    function automatic int pick_size(input logic [61:0] v);
        int si;
        if (v < 62'd64)
            si = 0;
        else if (v < 62'd16384)
            si = 1;
        else if (v < 62'd1073741824)
            si = 2;
        else
            si = 3;
        if ($urandom_range(0, 3) == 0)
            si = $urandom_range(si, 3);
        return 1 << si;
    endfunction

    task automatic put_byte(input logic [7:0] b);
        blk_q.insert(blk_q.size(), plain(b, 1'b0));
    endtask

    task automatic put_varint(input logic [61:0] v, input int sz);
        logic [63:0] w;
        logic [7:0]  b;
        w = {2'b00, v};
        for (int i = sz - 1; i >= 0; i--) begin
            b = w[8*i +: 8];
            if (i == sz - 1)
                b[7:6] = 2'($clog2(sz));
            put_byte(b);
        end
    endtask

    // One entry: mostly well formed, with the occasional bad length
    task automatic add_entry();
        logic [61:0] id;
        logic [61:0] v;
        int          len;
        int          sz;
        int          k;
        int          n0;
        k = $urandom_range(0, 9);
        if (k <= 3) begin
            // numeric parameter
            case ($urandom_range(0, 10))
                0:       id = 62'h01;
                10:      id = 62'h0e;
                default: id = 62'($urandom_range(3, 11));
            endcase
            sz  = 1 << $urandom_range(0, 3);
            v   = rand62() >> (64 - 8 * sz);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 9) : sz;
            put_varint(id, pick_size(id));
            put_varint(62'(len), pick_size(62'(len)));
            n0 = blk_q.size();
            put_varint(v, sz);
            while (blk_q.size() - n0 > len)
                void'(blk_q.pop_back());
            while (blk_q.size() - n0 < len)
                put_byte(8'($urandom));
        end else begin
            case (k)
                4, 5: begin
                    case ($urandom_range(0, 2))
                        0:       id = 62'h00;
                        1:       id = 62'h0f;
                        default: id = 62'h10;
                    endcase
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                      : $urandom_range(0, 6);
                end
                6: begin
                    id  = 62'h02;
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : 16;
                end
                7: begin
                    id  = 62'h0c;
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
                end
                default: begin
                    case ($urandom_range(0, 2))
                        0:       id = 62'h0d;
                        1:       id = 62'($urandom_range(17, 63));
                        default: id = rand62() >> $urandom_range(0, 61);
                    endcase
                    len = $urandom_range(0, 4);
                end
            endcase
            put_varint(id, pick_size(id));
            put_varint(62'(len), pick_size(62'(len)));
            repeat (len) put_byte(8'($urandom));
        end
    endtask

    // One block: a few entries, sometimes cut short or padded; now and then pure noise
    task automatic gen_block();
        int cut;
        blk_q.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) put_byte(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 4)) add_entry();
            case ($urandom_range(0, 9))
                0: begin
                    cut = $urandom_range(1, blk_q.size());
                    while (blk_q.size() > cut)
                        void'(blk_q.pop_back());
                end
                1:       repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
                default: ;
            endcase
        end
        blk_q[blk_q.size() - 1].last = 1'b1;
        foreach (blk_q[i])
            byte_q.insert(byte_q.size(), blk_q[i]);
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic cmp_field(input string name, input logic [63:0] e, input logic [63:0] a);
        if (a !== e) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, e, a);
        end
    endtask

    task automatic check_result();
        t_result e;
        if (pending_results.size() == 0) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("%0t: unexpected result: expected none, got kind %0d id 0x%0h end %0b",
                         $time, o_kind, o_param_id, o_block_end);
        end else begin
            e = pending_results.pop_front();
            cmp_field("kind",        64'(e.kind),        64'(o_kind));
            cmp_field("param_id",    64'(e.param_id),    64'(o_param_id));
            cmp_field("param_value", 64'(e.param_value), 64'(o_param_value));
            cmp_field("value_byte",  64'(e.value_byte),  64'(o_value_byte));
            cmp_field("value_last",  64'(e.value_last),  64'(o_value_last));
            cmp_field("block_end",   64'(e.block_end),   64'(o_block_end));
            cmp_field("status",      64'(e.status),      64'(o_status));
            kind_cnt[e.kind]++;
            if (e.block_end)
                block_cnt++;
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: predict on each transfer, then offer the next byte or idle
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit      produced;
        t_result r;
        if (push && !full) begin
            decode_byte(cur.b, cur.last, produced, r);
            // typed-in rows override the decoder's prediction
            if (cur.fixed)
                r = cur.res;
            if (produced)
                pending_results.insert(pending_results.size(), r);
            sent_cnt++;
            // reshuffle the idling mix now and then, including stretches with none
            if (sent_cnt % 100 == 0)
                case ($urandom_range(0, 3))
                    0:       tx_pct = 0;
                    1:       tx_pct = 8;
                    2:       tx_pct = 20;
                    default: tx_pct = 40;
                endcase
        end
        if (push && full)
            full_stalls++;
        calm = (byte_q.size() < CALM_TAIL);

        if (!run_io) begin
            push <= 1'b0;
        end else if (push && full) begin
            // hold the byte until it is taken
        end else if (tx_gap > 0) begin
            tx_gap--;
            push <= 1'b0;
        end else if (byte_q.size() != 0) begin
            // keep offering during the receiver hold-off so the block backs up
            if (!calm && rx_hold_cnt == 0 && tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
                tx_gap = $urandom_range(1, 19) - 1;
                push <= 1'b0;
            end else begin
                cur = byte_q.pop_front();
                push        <= 1'b1;
                i_wire_byte <= cur.b;
                i_wire_last <= cur.last;
            end
        end else begin
            push <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: check each popped result, then pop, idle or hold off
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (pop && !empty) begin
            check_result();
            if ((kind_cnt[0] + kind_cnt[1] + kind_cnt[2] + kind_cnt[3]) % 100 == 0)
                rx_pct = 10 * $urandom_range(0, 4);
        end

        if (!run_io) begin
            pop <= 1'b0;
        end else if (rx_hold_cnt > 0) begin
            rx_hold_cnt--;
            pop <= 1'b0;
        end else if (!hold_done && sent_cnt >= HOLD_AT) begin
            // long hold-off: let both queues fill and full rise
            hold_done   = 1'b1;
            rx_hold_cnt = HOLD_CYCLES - 1;
            pop <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            pop <= 1'b0;
        end else if (!calm && rx_pct != 0 && $urandom_range(0, 99) < rx_pct) begin
            rx_gap = $urandom_range(1, 19) - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // Watchdog: end the run if no transfer happens on either side for too long
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results still owed",
                     $time, WATCHDOG_LIMIT, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main flow
    // ------------------------------------------------------------------
    initial begin
        t_row dir_tab [0:25];
        clear_decoder();

        // Directed blocks, one per special case
        dir_tab = '{
            // id only, length missing: truncated
            closing(8'h00, KIND_END, 62'h0, 62'h0, STAT_TRUNC),
            // migration flag with an empty value, closing the block
            plain(8'h0c, 1'b0),
            closing(8'h00, KIND_EMPTY, 62'h0c, 62'h0, STAT_OK),
            // reset token with empty value fails at once; the next byte is dropped
            plain(8'h02, 1'b0), plain(8'h00, 1'b0),
            closing(8'hff, KIND_END, 62'h0, 62'h0, STAT_TOKEN_LEN),
            // numeric whose one-byte varint does not fill a two-byte field
            plain(8'h03, 1'b0), plain(8'h02, 1'b0), plain(8'h05, 1'b0),
            closing(8'h06, KIND_END, 62'h0, 62'h0, STAT_NUM_LEN),
            // flag that carries a value
            plain(8'h0c, 1'b0), plain(8'h01, 1'b0),
            closing(8'haa, KIND_END, 62'h0, 62'h0, STAT_FLAG),
            // opaque value cut off by the end of the block: overrun
            plain(8'h00, 1'b0), plain(8'h05, 1'b0), plain(8'h11, 1'b1),
            // numeric with the largest eight-byte value
            plain(8'h04, 1'b0), plain(8'h08, 1'b0),
            plain(8'hff, 1'b0), plain(8'hff, 1'b0), plain(8'hff, 1'b0), plain(8'hff, 1'b0),
            plain(8'hff, 1'b0), plain(8'hff, 1'b0), plain(8'hff, 1'b0),
            closing(8'hff, KIND_NUM, 62'h04, 62'h3fff_ffff_ffff_ffff, STAT_OK)
        };
        foreach (dir_tab[i])
            byte_q.insert(byte_q.size(), dir_tab[i]);

        // Random blocks follow the table
        while (byte_q.size() < $size(dir_tab) + RANDOM_BYTES)
            gen_block();
        total_bytes = byte_q.size();

        // Reset once, then release both sides
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_io  = 1'b1;

        while (sent_cnt != total_bytes)
            @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        // allow any stray result to surface
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes (%0d directed); %0d blocks closed, input stalled %0d cycles.",
                 total_bytes, $size(dir_tab), block_cnt, full_stalls);
        $display("Results checked: %0d numeric, %0d opaque bytes, %0d empty, %0d end only;",
                 kind_cnt[0], kind_cnt[1], kind_cnt[2], kind_cnt[3]);
        $display("%0d errors.", err_cnt);
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
